// ----- design/twc_pkg.sv -----
// ----------------------------------------------------------------------------
// twc_pkg
// Shared constants, register indexes, levels and beat types of the
// triggered waveform capture block.
// ----------------------------------------------------------------------------
package twc_pkg;

  localparam int PRE_DEPTH_DEF  = 32;
  localparam int POST_DEPTH_DEF = 32;
  localparam int INQ_DEPTH      = 2;
  localparam int OUTQ_DEPTH     = 4;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_BIAS_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BIAS_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BIAS_Z   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MINOR    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MODERATE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SEVERE   = 3'd5;

  localparam logic [15:0] MINOR_RST    = 16'd573;
  localparam logic [15:0] MODERATE_RST = 16'd1638;
  localparam logic [15:0] SEVERE_RST   = 16'd8192;

  localparam logic [1:0] LVL_MINOR    = 2'd0;
  localparam logic [1:0] LVL_MODERATE = 2'd1;
  localparam logic [1:0] LVL_SEVERE   = 2'd2;

  typedef struct packed {
    logic [31:0]        stime;
    logic signed [16:0] ax;
    logic signed [16:0] ay;
    logic signed [16:0] az;
  } sample_t;

  typedef struct packed {
    sample_t     smp;
    logic [15:0] dev;
    logic        ge_minor;
    logic        ge_moderate;
    logic        ge_severe;
  } item_t;

  typedef struct packed {
    logic signed [31:0] relative_time;
    logic signed [16:0] ax;
    logic signed [16:0] ay;
    logic signed [16:0] az;
    logic               phase;
    logic [1:0]         level;
    logic [15:0]        peak;
    logic               last;
  } result_t;

endpackage

// ----- design/twc_ram.sv -----
// ----------------------------------------------------------------------------
// twc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module twc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/twc_queue.sv -----
// ----------------------------------------------------------------------------
// twc_queue
// Small register FIFO with full, empty and fill count.
// ----------------------------------------------------------------------------
module twc_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty,
  output logic [CW-1:0]    count
);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- design/twc_front.sv -----
// ----------------------------------------------------------------------------
// twc_front
// Configuration registers, bias correction, deviation and threshold
// classification of each incoming sample.
// ----------------------------------------------------------------------------
module twc_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [twc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [twc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic [31:0]                     sample_time,
  input  logic signed [15:0]              raw_x,
  input  logic signed [15:0]              raw_y,
  input  logic signed [15:0]              raw_z,
  output twc_pkg::item_t                  item
);

  import twc_pkg::*;

  logic signed [15:0] bias_x;
  logic signed [15:0] bias_y;
  logic signed [15:0] bias_z;
  logic [15:0]        minor_thr;
  logic [15:0]        moderate_thr;
  logic [15:0]        severe_thr;

  logic signed [16:0] ax;
  logic signed [16:0] ay;
  logic signed [16:0] az;
  logic [15:0]        mx;
  logic [15:0]        my;
  logic [15:0]        mz;
  logic [15:0]        mxy;
  logic [15:0]        dev;

  function automatic logic [15:0] mag17(logic signed [16:0] v);
    logic [16:0] n;
    n = v[16] ? 17'(-v) : 17'(v);
    return n[15:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      bias_x       <= '0;
      bias_y       <= '0;
      bias_z       <= '0;
      minor_thr    <= MINOR_RST;
      moderate_thr <= MODERATE_RST;
      severe_thr   <= SEVERE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BIAS_X:   bias_x       <= cfg_data;
        REG_BIAS_Y:   bias_y       <= cfg_data;
        REG_BIAS_Z:   bias_z       <= cfg_data;
        REG_MINOR:    minor_thr    <= cfg_data;
        REG_MODERATE: moderate_thr <= cfg_data;
        REG_SEVERE:   severe_thr   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign ax  = 17'(raw_x) - 17'(bias_x);
  assign ay  = 17'(raw_y) - 17'(bias_y);
  assign az  = 17'(raw_z) - 17'(bias_z);
  assign mx  = mag17(ax);
  assign my  = mag17(ay);
  assign mz  = mag17(az);
  assign mxy = (my > mx) ? my : mx;
  assign dev = (mz > mxy) ? mz : mxy;

  always_comb begin
    item.smp.stime   = sample_time;
    item.smp.ax      = ax;
    item.smp.ay      = ay;
    item.smp.az      = az;
    item.dev         = dev;
    item.ge_minor    = (dev >= minor_thr);
    item.ge_moderate = (dev >= moderate_thr);
    item.ge_severe   = (dev >= severe_thr);
  end

endmodule

// ----- design/twc_back.sv -----
// ----------------------------------------------------------------------------
// twc_back
// Pre-trigger ring, post-trigger capture, peak tracking and the emission
// sequencer that reads both stores into result beats.
// ----------------------------------------------------------------------------
module twc_back #(
  parameter int PRE_DEPTH  = twc_pkg::PRE_DEPTH_DEF,
  parameter int POST_DEPTH = twc_pkg::POST_DEPTH_DEF,
  localparam int OQ_CW = $clog2(twc_pkg::OUTQ_DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  input  twc_pkg::item_t      item,
  output logic                item_pop,
  output logic                res_push,
  output twc_pkg::result_t    res,
  input  logic [OQ_CW-1:0]    res_count
);

  import twc_pkg::*;

  localparam int PRE_AW  = (PRE_DEPTH > 1) ? $clog2(PRE_DEPTH) : 1;
  localparam int PRE_CW  = $clog2(PRE_DEPTH + 1);
  localparam int POST_AW = (POST_DEPTH > 1) ? $clog2(POST_DEPTH) : 1;
  localparam int SW      = $bits(sample_t);

  localparam logic ST_RUN  = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic               state;
  logic               capturing;
  logic [PRE_AW-1:0]  ring_head;
  logic [PRE_CW-1:0]  ring_fill;
  logic [POST_AW-1:0] post_fill;
  logic [1:0]         held_level;
  logic [15:0]        held_peak;
  logic [31:0]        event_time;
  logic [PRE_CW-1:0]  pre_left;
  logic [PRE_AW-1:0]  pre_addr;
  logic [POST_AW-1:0] post_addr;
  logic               rd_valid;
  logic               rd_phase;
  logic               rd_last;

  logic               credit;
  logic               issue;
  logic               pre_issue;
  logic               post_issue;
  logic               trig;
  logic [1:0]         new_level;
  logic               ring_full;
  logic               post_end;
  logic               post_addr_end;
  logic [SW-1:0]      pre_rdata;
  logic [SW-1:0]      post_rdata;
  sample_t            rd_smp;

  assign item_pop      = item_valid && (state == ST_RUN);
  assign credit        = ({1'b0, res_count} + (OQ_CW + 1)'(rd_valid))
                         < (OQ_CW + 1)'(OUTQ_DEPTH);
  assign issue         = (state == ST_EMIT) && credit;
  assign pre_issue     = issue && (pre_left != '0);
  assign post_issue    = issue && (pre_left == '0);
  assign trig          = item.ge_minor || item.ge_moderate || item.ge_severe;
  assign new_level     = item.ge_severe ? LVL_SEVERE :
                         item.ge_moderate ? LVL_MODERATE : LVL_MINOR;
  assign ring_full     = (ring_fill == PRE_CW'(PRE_DEPTH));
  assign post_end      = (post_fill == POST_AW'(POST_DEPTH - 1));
  assign post_addr_end = (post_addr == POST_AW'(POST_DEPTH - 1));

  twc_ram #(.WIDTH(SW), .DEPTH(PRE_DEPTH)) u_pre_ram (
    .clk   (clk),
    .we    (item_pop && !capturing),
    .waddr (ring_head),
    .wdata (item.smp),
    .re    (pre_issue),
    .raddr (pre_addr),
    .rdata (pre_rdata)
  );

  twc_ram #(.WIDTH(SW), .DEPTH(POST_DEPTH)) u_post_ram (
    .clk   (clk),
    .we    (item_pop && capturing),
    .waddr (post_fill),
    .wdata (item.smp),
    .re    (post_issue),
    .raddr (post_addr),
    .rdata (post_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_RUN;
      capturing  <= 1'b0;
      ring_head  <= '0;
      ring_fill  <= '0;
      post_fill  <= '0;
      held_level <= LVL_MINOR;
      held_peak  <= '0;
      event_time <= '0;
      pre_left   <= '0;
      pre_addr   <= '0;
      post_addr  <= '0;
      rd_valid   <= 1'b0;
      rd_phase   <= 1'b0;
      rd_last    <= 1'b0;
    end else begin
      rd_valid <= issue;
      if (issue) begin
        rd_phase <= post_issue;
        rd_last  <= post_issue && post_addr_end;
      end
      unique case (state)
        ST_RUN: begin
          if (item_pop && !capturing) begin
            ring_head <= (ring_head == PRE_AW'(PRE_DEPTH - 1)) ? '0 : ring_head + 1'b1;
            if (!ring_full) begin
              ring_fill <= ring_fill + 1'b1;
            end
            if (trig) begin
              held_level <= new_level;
              capturing  <= 1'b1;
              held_peak  <= item.dev;
              event_time <= item.smp.stime;
              post_fill  <= '0;
            end
          end else if (item_pop) begin
            if (item.dev > held_peak) begin
              held_peak <= item.dev;
              if (item.ge_severe) begin
                held_level <= LVL_SEVERE;
              end else if (item.ge_moderate) begin
                held_level <= LVL_MODERATE;
              end
            end
            if (post_end) begin
              // start the drain from the oldest ring entry, then empty the ring
              state     <= ST_EMIT;
              capturing <= 1'b0;
              post_fill <= '0;
              pre_left  <= ring_fill;
              pre_addr  <= ring_full ? ring_head : '0;
              post_addr <= '0;
              ring_fill <= '0;
              ring_head <= '0;
            end else begin
              post_fill <= post_fill + 1'b1;
            end
          end
        end
        ST_EMIT: begin
          if (pre_issue) begin
            pre_left <= pre_left - 1'b1;
            pre_addr <= (pre_addr == PRE_AW'(PRE_DEPTH - 1)) ? '0 : pre_addr + 1'b1;
          end else if (post_issue) begin
            post_addr <= post_addr_end ? '0 : post_addr + 1'b1;
            if (post_addr_end) begin
              state <= ST_RUN;
            end
          end
        end
        default: state <= ST_RUN;
      endcase
    end
  end

  assign rd_smp   = rd_phase ? sample_t'(post_rdata) : sample_t'(pre_rdata);
  assign res_push = rd_valid;

  always_comb begin
    res.relative_time = rd_smp.stime - event_time;
    res.ax            = rd_smp.ax;
    res.ay            = rd_smp.ay;
    res.az            = rd_smp.az;
    res.phase         = rd_phase;
    res.level         = held_level;
    res.peak          = held_peak;
    res.last          = rd_last;
  end

endmodule

// ----- design/triggered_waveform_capture_top.sv -----
// ----------------------------------------------------------------------------
// triggered_waveform_capture_top
// Threshold-triggered accelerometer capture with a pre-trigger ring.
//
// Input channel: push a sample while full is low. The sample is bias
// corrected, classified and queued; outside a drain the back end takes
// one queued sample per cycle, whether idle or capturing.
// The sample that completes the post-trigger capture starts a drain of
// ring_fill + POST_DEPTH result beats, oldest pre sample first, last set
// on the final post beat. Drain beats follow one per cycle while pop is
// held, paced by the registered store read and a four-beat output queue.
// During the drain no sample is taken from the two-entry input queue, so
// full rises once that queue holds two samples. A stalled receiver holds
// the drain with no beat lost.
// Configuration: write cfg_data to register cfg_index with cfg_we, only
// while the block is idle. Reset empties the ring and queues, ends any
// capture and loads the default thresholds; sample stores are not cleared.
// ----------------------------------------------------------------------------
module triggered_waveform_capture_top #(
  parameter int PRE_DEPTH  = twc_pkg::PRE_DEPTH_DEF,
  parameter int POST_DEPTH = twc_pkg::POST_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  logic [31:0]                     sample_time,
  input  logic signed [15:0]              raw_x,
  input  logic signed [15:0]              raw_y,
  input  logic signed [15:0]              raw_z,
  output logic                            empty,
  input  logic                            pop,
  output logic signed [31:0]              relative_time,
  output logic signed [16:0]              accel_x,
  output logic signed [16:0]              accel_y,
  output logic signed [16:0]              accel_z,
  output logic                            phase,
  output logic [1:0]                      event_level,
  output logic [15:0]                     peak_deviation,
  output logic                            last,
  input  logic                            cfg_we,
  input  logic [twc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [twc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  import twc_pkg::*;

  localparam int IW    = $bits(item_t);
  localparam int RW    = $bits(result_t);
  localparam int IQ_CW = $clog2(INQ_DEPTH + 1);
  localparam int OQ_CW = $clog2(OUTQ_DEPTH + 1);

  item_t            front_item;
  item_t            back_item;
  logic [IW-1:0]    inq_rdata;
  logic             inq_empty;
  logic [IQ_CW-1:0] inq_count;
  logic             item_pop;
  logic             res_push;
  result_t          back_res;
  result_t          out_res;
  logic [RW-1:0]    outq_rdata;
  logic             outq_full;
  logic [OQ_CW-1:0] outq_count;

  twc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .sample_time (sample_time),
    .raw_x       (raw_x),
    .raw_y       (raw_y),
    .raw_z       (raw_z),
    .item        (front_item)
  );

  twc_queue #(.WIDTH(IW), .DEPTH(INQ_DEPTH)) u_inq (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (front_item),
    .full  (full),
    .pop   (item_pop),
    .rdata (inq_rdata),
    .empty (inq_empty),
    .count (inq_count)
  );

  assign back_item = item_t'(inq_rdata);

  twc_back #(.PRE_DEPTH(PRE_DEPTH), .POST_DEPTH(POST_DEPTH)) u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (!inq_empty),
    .item       (back_item),
    .item_pop   (item_pop),
    .res_push   (res_push),
    .res        (back_res),
    .res_count  (outq_count)
  );

  twc_queue #(.WIDTH(RW), .DEPTH(OUTQ_DEPTH)) u_outq (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (back_res),
    .full  (outq_full),
    .pop   (pop),
    .rdata (outq_rdata),
    .empty (empty),
    .count (outq_count)
  );

  assign out_res        = result_t'(outq_rdata);
  assign relative_time  = out_res.relative_time;
  assign accel_x        = out_res.ax;
  assign accel_y        = out_res.ay;
  assign accel_z        = out_res.az;
  assign phase          = out_res.phase;
  assign event_level    = out_res.level;
  assign peak_deviation = out_res.peak;
  assign last           = out_res.last;

  a_no_outq_overflow: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !outq_full)
    else $error("result beat pushed into a full output queue");

  a_no_inq_underflow: assert property (@(posedge clk) disable iff (rst)
    item_pop |-> (inq_count != '0))
    else $error("sample taken from an empty input queue");

  a_last_is_post: assert property (@(posedge clk) disable iff (rst)
    (!empty && last) |-> phase)
    else $error("final beat of a waveform is not a post sample");

endmodule

// ----- tb/tb_triggered_waveform_capture_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_triggered_waveform_capture_top
// Self-checking testbench for the triggered waveform capture block.
//
// A queue-fed driver pushes timestamped samples. Every accepted sample goes
// through a behavioral model of the bias correction, pre-trigger ring and
// post-trigger capture, which queues the expected waveform beats. A monitor
// pops beats and compares each one field by field with the oldest expected
// beat. The run steps through several register settings: defaults, extreme
// biases and thresholds, zero thresholds, unordered thresholds and random
// values. It mixes sender gaps, receiver stalls and one long receiver
// hold-off that backs the block up until it refuses input.
// ----------------------------------------------------------------------------
module tb_triggered_waveform_capture_top;
  import twc_pkg::*;

  localparam int PRE_N  = PRE_DEPTH_DEF;
  localparam int POST_N = POST_DEPTH_DEF;
  localparam int SETTLE = 16;
  localparam int HOLD_CYCLES = 300;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef struct {
    logic [31:0]        t;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } raw_sample_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic [31:0] sample_time = '0;
  logic signed [15:0] raw_x = '0;
  logic signed [15:0] raw_y = '0;
  logic signed [15:0] raw_z = '0;
  logic empty;
  logic pop = 1'b0;
  logic signed [31:0] relative_time;
  logic signed [16:0] accel_x;
  logic signed [16:0] accel_y;
  logic signed [16:0] accel_z;
  logic phase;
  logic [1:0] event_level;
  logic [15:0] peak_deviation;
  logic last;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  triggered_waveform_capture_top u_dut (
    .clk(clk), .rst(rst),
    .push(push), .full(full),
    .sample_time(sample_time), .raw_x(raw_x), .raw_y(raw_y), .raw_z(raw_z),
    .empty(empty), .pop(pop),
    .relative_time(relative_time), .accel_x(accel_x), .accel_y(accel_y),
    .accel_z(accel_z), .phase(phase), .event_level(event_level),
    .peak_deviation(peak_deviation), .last(last),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // model state
  logic signed [15:0] bias_x = '0;
  logic signed [15:0] bias_y = '0;
  logic signed [15:0] bias_z = '0;
  logic [15:0] thr_minor = MINOR_RST;
  logic [15:0] thr_moderate = MODERATE_RST;
  logic [15:0] thr_severe = SEVERE_RST;
  sample_t pre_mem [PRE_N];
  sample_t post_mem [POST_N];
  int ring_head = 0;
  int ring_fill = 0;
  int post_cnt = 0;
  logic cap_active = 1'b0;
  logic [1:0] cap_level = LVL_MINOR;
  logic [15:0] cap_peak = '0;
  logic [31:0] event_stamp = '0;

  raw_sample_t sample_q [$];
  result_t waveform_q [$];
  raw_sample_t nxt;
  result_t want;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;
  logic [31:0] next_time = 32'hFFFF_FFF8;
  logic jumps_on = 1'b0;

  int fail_count = 0;
  int samples_sent = 0;
  int beats_checked = 0;
  int full_cycles = 0;
  int captures [3] = '{0, 0, 0};

  function automatic logic [15:0] mag17(logic signed [16:0] v);
    logic [16:0] m;
    m = v[16] ? -v : v;
    return m[15:0];
  endfunction

  function automatic logic signed [15:0] sat16(int v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  task automatic capture_sample(input logic [31:0] t, input logic signed [15:0] x,
                                input logic signed [15:0] y,
                                input logic signed [15:0] z);
    sample_t s;
    logic [15:0] dev;
    result_t r;
    int start;
    s.stime = t;
    s.ax = $signed({x[15], x}) - $signed({bias_x[15], bias_x});
    s.ay = $signed({y[15], y}) - $signed({bias_y[15], bias_y});
    s.az = $signed({z[15], z}) - $signed({bias_z[15], bias_z});
    dev = mag17(s.ax);
    if (mag17(s.ay) > dev) dev = mag17(s.ay);
    if (mag17(s.az) > dev) dev = mag17(s.az);

    if (!cap_active) begin
      pre_mem[ring_head] = s;
      ring_head = (ring_head + 1) % PRE_N;
      if (ring_fill < PRE_N) ring_fill++;
      if (dev >= thr_minor || dev >= thr_moderate || dev >= thr_severe) begin
        if (dev >= thr_severe) cap_level = LVL_SEVERE;
        else if (dev >= thr_moderate) cap_level = LVL_MODERATE;
        else cap_level = LVL_MINOR;
        cap_active = 1'b1;
        cap_peak = dev;
        event_stamp = t;
        post_cnt = 0;
      end
      return;
    end

    if (dev > cap_peak) begin
      cap_peak = dev;
      if (dev >= thr_severe) cap_level = LVL_SEVERE;
      else if (dev >= thr_moderate) cap_level = LVL_MODERATE;
    end
    post_mem[post_cnt] = s;
    post_cnt++;
    if (post_cnt < POST_N) return;

    start = (ring_head + PRE_N - ring_fill) % PRE_N;
    for (int i = 0; i < ring_fill + POST_N; i++) begin
      s = (i < ring_fill) ? pre_mem[(start + i) % PRE_N] : post_mem[i - ring_fill];
      r.relative_time = s.stime - event_stamp;
      r.ax = s.ax;
      r.ay = s.ay;
      r.az = s.az;
      r.phase = (i >= ring_fill);
      r.level = cap_level;
      r.peak = cap_peak;
      r.last = (i == ring_fill + POST_N - 1);
      waveform_q.push_back(r);
    end
    captures[cap_level]++;
    cap_active = 1'b0;
    post_cnt = 0;
    ring_fill = 0;
    ring_head = 0;
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && full) full_cycles++;
      if (push && !full) begin
        capture_sample(sample_time, raw_x, raw_y, raw_z);
        samples_sent++;
      end
      if (!push || !full) begin
        if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = sample_q.pop_front();
          sample_time <= nxt.t;
          raw_x <= nxt.x;
          raw_y <= nxt.y;
          raw_z <= nxt.z;
          push <= 1'b1;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (hold_left > 0) hold_left <= hold_left - 1;
  end

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s mismatch: expected %h, got %h", name, exp_v, got_v);
      fail_count++;
    end
  endtask

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (waveform_q.size() == 0) begin
          $error("beat with no expected beat waiting: relative_time %h", relative_time);
          fail_count++;
        end else begin
          want = waveform_q.pop_front();
          check_field("relative_time", want.relative_time, relative_time);
          check_field("accel_x", want.ax, accel_x);
          check_field("accel_y", want.ay, accel_y);
          check_field("accel_z", want.az, accel_z);
          check_field("phase", want.phase, phase);
          check_field("event_level", want.level, event_level);
          check_field("peak_deviation", want.peak, peak_deviation);
          check_field("last", want.last, last);
          beats_checked++;
        end
      end
      pop <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic add_item(input logic signed [15:0] x, input logic signed [15:0] y,
                          input logic signed [15:0] z);
    raw_sample_t s;
    s.t = next_time;
    s.x = x;
    s.y = y;
    s.z = z;
    sample_q.push_back(s);
    if (jumps_on && $urandom_range(24) == 0) next_time = $urandom;
    else next_time += jumps_on ? $urandom_range(1, 40) : 1;
  endtask

  function automatic int quiet_delta();
    int q;
    q = thr_minor;
    if (thr_moderate < q) q = thr_moderate;
    if (thr_severe < q) q = thr_severe;
    if (q <= 1) return 0;
    q = $urandom_range(0, q - 1);
    return $urandom_range(1) ? q : -q;
  endfunction

  task automatic add_quiet();
    add_item(sat16(bias_x + quiet_delta()), sat16(bias_y + quiet_delta()),
             sat16(bias_z + quiet_delta()));
  endtask

  task automatic add_noise();
    add_item($urandom, $urandom, $urandom);
  endtask

  task automatic add_spike();
    int d;
    int dlt [3];
    case ($urandom_range(3))
      0: d = thr_minor;
      1: d = thr_moderate;
      2: d = thr_severe;
      default: d = $urandom_range(0, 65535);
    endcase
    if (d != 0 && $urandom_range(1)) d += $urandom_range(0, 2) - 1;
    dlt = '{0, 0, 0};
    dlt[$urandom_range(2)] = $urandom_range(1) ? -d : d;
    add_item(sat16(bias_x + dlt[0]), sat16(bias_y + dlt[1]), sat16(bias_z + dlt[2]));
  endtask

  task automatic add_event(input int n_pre, input int n_post);
    int r;
    repeat (n_pre) add_quiet();
    add_spike();
    repeat (n_post) begin
      r = $urandom_range(99);
      if (r < 50) add_quiet();
      else if (r < 80) add_spike();
      else add_noise();
    end
  endtask

  task automatic add_random(input int n);
    int goal;
    int r;
    goal = sample_q.size() + n;
    while (sample_q.size() < goal) begin
      r = $urandom_range(99);
      if (r < 75) add_event($urandom_range(0, 45), POST_N);
      else if (r < 88) repeat ($urandom_range(1, 4)) add_noise();
      else add_event($urandom_range(0, 10), $urandom_range(0, POST_N - 1));
    end
  endtask

  // run the queue dry, close any open capture, then wait out the drain
  task automatic drain_phase();
    do begin
      while (sample_q.size() != 0 || push) @(negedge clk);
      if (cap_active) repeat (POST_N - post_cnt) add_quiet();
    end while (cap_active || sample_q.size() != 0);
    while (waveform_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_BIAS_X:   bias_x = val;
      REG_BIAS_Y:   bias_y = val;
      REG_BIAS_Z:   bias_z = val;
      REG_MINOR:    thr_minor = val;
      REG_MODERATE: thr_moderate = val;
      REG_SEVERE:   thr_severe = val;
      default: ;
    endcase
  endtask

  task automatic apply_config(input logic [15:0] bx, input logic [15:0] by,
                              input logic [15:0] bz, input logic [15:0] mi,
                              input logic [15:0] mo, input logic [15:0] se);
    write_reg(REG_BIAS_X, bx);
    write_reg(REG_BIAS_Y, by);
    write_reg(REG_BIAS_Z, bz);
    write_reg(REG_MINOR, mi);
    write_reg(REG_MODERATE, mo);
    write_reg(REG_SEVERE, se);
    write_reg($urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO, $urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // defaults: threshold edges, peak updates, timestamp wrap, extremes
    set_idling(0, 0);
    add_item(0, 0, 0);
    add_item(572, -572, 0);
    add_item(0, 0, -572);
    add_item(-572, 572, 572);
    add_item(-573, 0, 0);
    add_item(0, 573, 0);
    add_item(0, 0, 1637);
    add_item(1638, 0, 0);
    add_item(0, -8191, 0);
    add_item(0, 0, 8192);
    add_item(100, -100, 50);
    add_item(16'h7FFF, 0, 0);
    add_item(16'h8000, 16'h8000, 16'h8000);
    add_item(16'h7FFF, 16'h7FFF, 16'h7FFF);
    add_item(16'h5555, 16'hAAAA, 16'h5555);
    add_item(16'hAAAA, 16'h5555, 16'hAAAA);
    drain_phase();
    jumps_on = 1'b1;
    add_random(25);
    drain_phase();

    // extreme biases, top thresholds, sender gaps
    apply_config(16'h7FFF, 16'h8000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    set_idling(46, 0);
    add_item(16'h8000, 16'h7FFF, 0);
    add_random(25);
    drain_phase();

    // zero thresholds: every idle sample triggers
    apply_config(16'(-200), 16'd150, 16'd7, 16'd0, 16'd0, 16'd0);
    set_idling(0, 46);
    add_random(25);
    drain_phase();

    // unordered thresholds
    apply_config(16'd1000, 16'(-1000), 16'd0, 16'd3000, 16'd200, 16'd1500);
    set_idling(20, 20);
    add_random(25);
    drain_phase();

    // long receiver hold-off while samples keep coming
    apply_config(16'(int'($urandom_range(0, 400)) - 200), 16'(int'($urandom_range(0, 400)) - 200),
                 16'(int'($urandom_range(0, 400)) - 200), 16'd100, 16'd400, 16'd2000);
    set_idling(0, 0);
    add_event(5, POST_N);
    add_random(15);
    hold_left = HOLD_CYCLES;
    drain_phase();

    // random settings
    apply_config($urandom, $urandom, $urandom, $urandom_range(0, 65535),
                 $urandom_range(0, 65535), $urandom_range(0, 65535));
    set_idling(20, 20);
    add_random(25);
    drain_phase();

    $display("Run covered %0d samples and %0d waveform beats over six register settings",
             samples_sent, beats_checked);
    $display("Captures: %0d minor, %0d moderate, %0d severe; input held by full %0d cycles",
             captures[LVL_MINOR], captures[LVL_MODERATE], captures[LVL_SEVERE], full_cycles);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timeout with %0d beats still expected", waveform_q.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule
